// File: rtl/core/fit_policy_block_allocator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fit-policy block allocator
// Shared property wrappers clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_MACROS_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_MACROS_SVH

// Check an implication on every clock edge outside reset
`define FPBA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that an expression holds steady while a condition holds
`define FPBA_ASSERT_HOLD(label, cond, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond) |=> $stable(expr)) else $error(msg);

`endif

// File: rtl/core/fpba_pkg.sv
// ----------------------------------------------------------------------------
// Fit-policy block allocator package
// Table sizes, register indexes, policy codes and controller states.
// ----------------------------------------------------------------------------
package fpba_pkg;

  // Table geometry
  localparam int MAX_BLOCKS = 16;
  localparam int SIZE_BITS  = 16;
  localparam int IDX_BITS   = $clog2(MAX_BLOCKS);
  localparam int CNT_BITS   = $clog2(MAX_BLOCKS + 1);

  // Fixed field widths
  localparam int SLOT_W  = 4;
  localparam int SIZE_W  = 16;
  localparam int COUNT_W = 5;
  localparam int MODE_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd1;

  // Placement policy codes; any other code acts as first fit
  localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

  // Item opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  // Reset values of the registers
  localparam logic [MODE_W-1:0]  FIT_MODE_RST    = FIT_FIRST;
  localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_e;

endpackage

// File: rtl/core/fpba_if.sv
// ----------------------------------------------------------------------------
// Fit-policy block allocator channels
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface fpba_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [3:0]  block_slot;
  logic [15:0] size;
  logic        last_request;

  modport source (output valid, op, block_slot, size, last_request, input ready);
  modport sink   (input valid, op, block_slot, size, last_request, output ready);
endinterface

interface fpba_out_if;
  logic        valid;
  logic        ready;
  logic        granted;
  logic [3:0]  block_index;
  logic [15:0] block_left;

  modport source (output valid, granted, block_index, block_left, input ready);
  modport sink   (input valid, granted, block_index, block_left, output ready);
endinterface

// File: rtl/core/fit_policy_block_allocator.sv
// ----------------------------------------------------------------------------
// Fit-policy block allocator
// Block table with first, best and worst fit placement over a scan.
// ----------------------------------------------------------------------------
// A load item writes a block size into the original and free tables. An
// allocate item occupies the block while it transfers, reads min(block_count,
// 16) table entries from the free/original memories (one read port each, one
// entry a cycle), resolves the last read, closes the scan, and then writes the
// reduced size back and fills the output register. The write-back step
// stretches while the previous result still waits in the output register. The
// output register lets the next item transfer while a result waits. A last
// request restores the free sizes by dropping per-entry override bits, so that
// unwritten free entries read through to the originals.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fpba_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fpba_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  fpba_in_if.sink                         in_i,
  fpba_out_if.source                      out_o
);

  // Configuration registers
  logic [fpba_pkg::MODE_W-1:0]  fit_mode_q;
  logic [fpba_pkg::COUNT_W-1:0] block_count_q;

  // Table memories and their valid bits
  logic [fpba_pkg::SIZE_BITS-1:0] orig_mem [fpba_pkg::MAX_BLOCKS];
  logic [fpba_pkg::SIZE_BITS-1:0] free_mem [fpba_pkg::MAX_BLOCKS];
  logic [fpba_pkg::MAX_BLOCKS-1:0] orig_vld_q;
  logic [fpba_pkg::MAX_BLOCKS-1:0] free_vld_q;

  // Read port outputs
  logic [fpba_pkg::SIZE_BITS-1:0] orig_rd_q, free_rd_q;
  logic                           ov_rd_q, fv_rd_q;
  logic                           rd_pend_q;
  logic [fpba_pkg::IDX_BITS-1:0]  rd_idx_q;

  // Request context and search state
  fpba_pkg::state_e               state_q, state_d;
  logic [fpba_pkg::CNT_BITS-1:0]  cnt_q, limit_q;
  logic [fpba_pkg::SIZE_BITS-1:0] req_q;
  logic                           last_q;
  logic                           found_q;
  logic [fpba_pkg::IDX_BITS-1:0]  best_idx_q;
  logic [fpba_pkg::SIZE_BITS-1:0] best_val_q;

  // Output register
  logic                           out_vld_q;
  logic                           out_granted_q;
  logic [fpba_pkg::SLOT_W-1:0]    out_idx_q;
  logic [fpba_pkg::SIZE_W-1:0]    out_left_q;

  // Control
  logic                           in_ready;
  logic                           in_xfer, load_xfer, alloc_xfer;
  logic                           rd_en, fin_en;
  logic                           slot_ok;
  logic [fpba_pkg::IDX_BITS-1:0]  load_addr, rd_addr;
  logic [fpba_pkg::SIZE_BITS-1:0] load_size, eff_val, left_val;
  logic [fpba_pkg::CNT_BITS-1:0]  limit_d;
  logic                           fits, take;

  assign in_xfer    = in_i.valid && in_ready;
  assign load_xfer  = in_xfer && (in_i.op == fpba_pkg::OP_LOAD);
  assign alloc_xfer = in_xfer && (in_i.op == fpba_pkg::OP_ALLOC);
  assign slot_ok    = 32'(in_i.block_slot) < fpba_pkg::MAX_BLOCKS;
  assign load_addr  = fpba_pkg::IDX_BITS'(in_i.block_slot);
  assign load_size  = fpba_pkg::SIZE_BITS'(in_i.size);
  assign rd_addr    = cnt_q[fpba_pkg::IDX_BITS-1:0];

  // Clamp the scan length to the table depth
  always_comb begin
    if (32'(block_count_q) > fpba_pkg::MAX_BLOCKS) begin
      limit_d = fpba_pkg::CNT_BITS'(fpba_pkg::MAX_BLOCKS);
    end else begin
      limit_d = fpba_pkg::CNT_BITS'(block_count_q);
    end
  end

  // Sequence the scan and the write-back
  always_comb begin
    state_d  = state_q;
    in_ready = 1'b0;
    rd_en    = 1'b0;
    fin_en   = 1'b0;
    case (state_q)
      fpba_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid && in_i.op == fpba_pkg::OP_ALLOC) begin
          state_d = fpba_pkg::ST_SCAN;
        end
      end
      fpba_pkg::ST_SCAN: begin
        rd_en = cnt_q < limit_q;
        if (!rd_en && !rd_pend_q) begin
          state_d = fpba_pkg::ST_WRITE;
        end
      end
      fpba_pkg::ST_WRITE: begin
        if (!out_vld_q || out_o.ready) begin
          fin_en  = 1'b1;
          state_d = fpba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fpba_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fpba_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Take configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q    <= fpba_pkg::FIT_MODE_RST;
      block_count_q <= fpba_pkg::BLOCK_COUNT_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == fpba_pkg::REG_FIT_MODE) begin
        fit_mode_q <= cfg_wdata_i[fpba_pkg::MODE_W-1:0];
      end else if (cfg_idx_i == fpba_pkg::REG_BLOCK_COUNT) begin
        block_count_q <= cfg_wdata_i[fpba_pkg::COUNT_W-1:0];
      end
    end
  end

  // Write and read the table memories
  always_ff @(posedge clk_i) begin
    if (load_xfer && slot_ok) begin
      orig_mem[load_addr] <= load_size;
      free_mem[load_addr] <= load_size;
    end else if (fin_en && found_q && !last_q) begin
      free_mem[best_idx_q] <= left_val;
    end
    if (rd_en) begin
      orig_rd_q <= orig_mem[rd_addr];
      free_rd_q <= free_mem[rd_addr];
    end
  end

  // Track which entries hold written data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orig_vld_q <= '0;
      free_vld_q <= '0;
      ov_rd_q    <= 1'b0;
      fv_rd_q    <= 1'b0;
      rd_pend_q  <= 1'b0;
      rd_idx_q   <= '0;
    end else begin
      if (load_xfer && slot_ok) begin
        orig_vld_q[load_addr] <= 1'b1;
        free_vld_q[load_addr] <= 1'b1;
      end else if (fin_en && last_q) begin
        free_vld_q <= '0;
      end else if (fin_en && found_q) begin
        free_vld_q[best_idx_q] <= 1'b1;
      end
      rd_pend_q <= rd_en;
      if (rd_en) begin
        ov_rd_q  <= orig_vld_q[rd_addr];
        fv_rd_q  <= free_vld_q[rd_addr];
        rd_idx_q <= rd_addr;
      end
    end
  end

  // Resolve the current free size and pick by policy
  always_comb begin
    if (fv_rd_q) begin
      eff_val = free_rd_q;
    end else if (ov_rd_q) begin
      eff_val = orig_rd_q;
    end else begin
      eff_val = '0;
    end
    fits = eff_val >= req_q;
    if (!found_q) begin
      take = fits;
    end else if (fit_mode_q == fpba_pkg::FIT_BEST) begin
      take = fits && (eff_val < best_val_q);
    end else if (fit_mode_q == fpba_pkg::FIT_WORST) begin
      take = fits && (eff_val > best_val_q);
    end else begin
      take = 1'b0;
    end
  end

  assign left_val = best_val_q - req_q;

  // Hold the request and the best candidate so far
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      found_q <= 1'b0;
    end else begin
      if (alloc_xfer) begin
        cnt_q   <= '0;
        found_q <= 1'b0;
      end else begin
        if (rd_en) begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (rd_pend_q && take) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (alloc_xfer) begin
      req_q   <= load_size;
      last_q  <= in_i.last_request;
      limit_q <= limit_d;
    end
    if (rd_pend_q && take) begin
      best_idx_q <= rd_idx_q;
      best_val_q <= eff_val;
    end
  end

  // Fill the output register and release it on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fin_en) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_en) begin
      out_granted_q <= found_q;
      out_idx_q     <= found_q ? fpba_pkg::SLOT_W'(best_idx_q) : '0;
      out_left_q    <= found_q ? fpba_pkg::SIZE_W'(left_val) : '0;
    end
  end

  assign in_i.ready        = in_ready;
  assign out_o.valid       = out_vld_q;
  assign out_o.granted     = out_granted_q;
  assign out_o.block_index = out_idx_q;
  assign out_o.block_left  = out_left_q;

endmodule

// File: rtl/core/fpba_checker.sv
// ----------------------------------------------------------------------------
// Fit-policy block allocator port checker
// Watches the channel ports of the allocator over time.
// ----------------------------------------------------------------------------
`include "fit_policy_block_allocator_macros.svh"

module fpba_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_op,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_granted,
  input logic [3:0]  out_block_index,
  input logic [15:0] out_block_left
);

  // A refused request reports zero index and zero space
  `FPBA_ASSERT(a_nogrant_zero, (out_valid && !out_granted) |-> (out_block_index == 4'd0 && out_block_left == 16'd0), "refused result carries nonzero fields")

  // A stalled result holds its payload
  `FPBA_ASSERT_HOLD(a_out_hold, out_valid && !out_ready, {out_valid, out_granted, out_block_index, out_block_left}, "stalled result changed")

  // An allocate transfer starts a scan, so the input closes
  `FPBA_ASSERT(a_alloc_busy, (in_valid && in_ready && in_op) |=> !in_ready, "input open during scan")

  // A load transfer completes at once
  `FPBA_ASSERT(a_load_idle, (in_valid && in_ready && !in_op) |=> in_ready, "input closed after load")

endmodule

bind fit_policy_block_allocator fpba_checker u_fpba_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid        (in_i.valid),
  .in_ready        (in_i.ready),
  .in_op           (in_i.op),
  .out_valid       (out_o.valid),
  .out_ready       (out_o.ready),
  .out_granted     (out_o.granted),
  .out_block_index (out_o.block_index),
  .out_block_left  (out_o.block_left)
);
